// File: sv/crd_pkg.sv
// ---------------------------------------------------------------------------
// crd_pkg
// Shared types and constants of the run-length row decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crd_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = 12;
  localparam int WIDTH_W     = 13;
  localparam int RUN_W       = 7;
  localparam int COUNT_W     = 16;
  localparam int CFG_IDX_W   = 1;

  typedef logic [1:0]         func_t;
  typedef logic [1:0]         status_t;
  typedef logic [1:0]         depth_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [RUN_W-1:0]   run_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam func_t FUNC_PUSH = 2'd0;
  localparam func_t FUNC_READ = 2'd1;
  localparam func_t FUNC_END  = 2'd2;

  localparam status_t ST_ROW_DONE  = 2'd0;
  localparam status_t ST_PIXEL     = 2'd1;
  localparam status_t ST_END_CLEAN = 2'd2;
  localparam status_t ST_TRUNCATED = 2'd3;

  localparam depth_t DEPTH_8 = 2'd0;
  localparam depth_t DEPTH_4 = 2'd1;
  localparam depth_t DEPTH_1 = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE  = 1'd1;

  localparam width_t MAX_WIDTH = 13'd4096;
  localparam count_t COUNT_MAX = 16'hffff;

  // Parser phase within the coded row.
  typedef enum logic [4:0] {
    PH_PREFIX0 = 5'b00001,
    PH_PREFIX1 = 5'b00010,
    PH_CONTROL = 5'b00100,
    PH_FILL    = 5'b01000,
    PH_LITERAL = 5'b10000
  } phase_t;

  // Sequencer state.
  typedef enum logic [3:0] {
    SQ_CLEAR = 4'b0001,
    SQ_IDLE  = 4'b0010,
    SQ_FILL  = 4'b0100,
    SQ_READ  = 4'b1000
  } seq_t;

endpackage

`default_nettype wire

// File: sv/crd_req_if.sv
// ---------------------------------------------------------------------------
// crd_req_if
// Request channel: stream bytes, pixel reads and end of data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crd_req_if;
  import crd_pkg::*;

  logic          valid;
  logic          ready;
  func_t         func;
  logic [7:0]    data_byte;
  addr_t         column;

  modport source (output valid, func, data_byte, column, input ready);
  modport sink   (input valid, func, data_byte, column, output ready);
endinterface

`default_nettype wire

// File: sv/crd_rsp_if.sv
// ---------------------------------------------------------------------------
// crd_rsp_if
// Result channel: row lengths, pixel indexes and end-of-data status.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crd_rsp_if;
  import crd_pkg::*;

  logic          valid;
  logic          ready;
  status_t       status;
  count_t        row_length;
  logic [7:0]    pixel_index;

  modport source (output valid, status, row_length, pixel_index, input ready);
  modport sink   (input valid, status, row_length, pixel_index, output ready);
endinterface

`default_nettype wire

// File: sv/crd_cfg_if.sv
// ---------------------------------------------------------------------------
// crd_cfg_if
// Register write channel: register index and write data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crd_cfg_if;
  import crd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  width_t               data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/cut_rle_row_decoder.sv
// ---------------------------------------------------------------------------
// cut_rle_row_decoder
// Run-length row decoder with a 4096-byte line store and pixel read-out.
// ---------------------------------------------------------------------------
// After reset the block sweeps the line store to zero, one byte a cycle, and
// accepts no request until the sweep is done (register writes are taken
// throughout). A stream byte is then handled in the idle state, except the
// data byte of a fill run, which then holds off requests while its bytes,
// up to 127, are written: the store has a single write port and the run is
// laid down by one address counter and limit compare. A pixel read goes
// through the registered store read and then the field pick. Results wait
// in an output register; a new request is taken in the idle state when
// that register is empty or being emptied.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cut_rle_row_decoder #(
  parameter int MAX_ROW_BYTES = 4096
) (
  input  wire logic clk,
  input  wire logic rst,
  crd_req_if.sink   req,
  crd_rsp_if.source rsp,
  crd_cfg_if.sink   cfg
);
  import crd_pkg::*;

  localparam int ROW_CAP_I = (MAX_ROW_BYTES > STORE_DEPTH) ? STORE_DEPTH : MAX_ROW_BYTES;
  localparam width_t ROW_CAP = WIDTH_W'(ROW_CAP_I);

  // Registers
  seq_t       seq, seq_next;
  phase_t     phase, phase_next;
  run_t       run_left, run_left_next;
  count_t     row_count, row_count_next;
  width_t     image_width;
  depth_t     depth_mode;
  addr_t      clr_addr;
  width_t     fill_pos, fill_pos_next;
  run_t       fill_left, fill_left_next;
  logic [7:0] fill_byte, fill_byte_next;
  logic [2:0] rd_sel;
  logic       rsp_valid, rsp_valid_next;
  status_t    rsp_status, rsp_status_next;
  count_t     rsp_len, rsp_len_next;
  logic [7:0] rsp_pix, rsp_pix_next;

  // Line store
  logic [7:0] store [STORE_DEPTH];
  logic       mem_we;
  addr_t      mem_wa;
  logic [7:0] mem_wd;
  logic       mem_re;
  addr_t      mem_ra;
  logic [7:0] mem_rd;

  logic       take;
  width_t     w_clamp;
  logic [13:0] w_ext;
  width_t     bytes;
  width_t     limit;
  logic [16:0] sum_run;
  logic [16:0] sum_one;
  count_t     count_run;
  count_t     count_one;
  run_t       run_in;
  logic [7:0] pix_sel;

  assign cfg.ready   = 1'b1;
  assign req.ready   = (seq == SQ_IDLE) && (!rsp_valid || rsp.ready);
  assign take        = req.valid && req.ready;

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.row_length  = rsp_len;
  assign rsp.pixel_index = rsp_pix;

  // Row byte length from width and depth
  always_comb begin
    w_clamp = (image_width > MAX_WIDTH) ? MAX_WIDTH : image_width;
    w_ext   = {1'b0, w_clamp};
    unique case (depth_mode)
      DEPTH_4: bytes = WIDTH_W'((w_ext + 14'd1) >> 1);
      DEPTH_1: bytes = WIDTH_W'((w_ext + 14'd7) >> 3);
      default: bytes = w_clamp;
    endcase
    limit = (bytes > ROW_CAP) ? ROW_CAP : bytes;
  end

  assign run_in    = req.data_byte[RUN_W-1:0];
  assign sum_run   = {1'b0, row_count} + {10'd0, run_left};
  assign sum_one   = {1'b0, row_count} + 17'd1;
  assign count_run = sum_run[COUNT_W] ? COUNT_MAX : sum_run[COUNT_W-1:0];
  assign count_one = sum_one[COUNT_W] ? COUNT_MAX : sum_one[COUNT_W-1:0];

  // Pick the requested field out of the stored byte
  always_comb begin
    unique case (depth_mode)
      DEPTH_4: pix_sel = rd_sel[0] ? {4'd0, mem_rd[3:0]} : {4'd0, mem_rd[7:4]};
      DEPTH_1: pix_sel = {7'd0, mem_rd[3'd7 - rd_sel]};
      default: pix_sel = mem_rd;
    endcase
  end

  always_comb begin
    seq_next        = seq;
    phase_next      = phase;
    run_left_next   = run_left;
    row_count_next  = row_count;
    fill_pos_next   = fill_pos;
    fill_left_next  = fill_left;
    fill_byte_next  = fill_byte;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_status_next = rsp_status;
    rsp_len_next    = rsp_len;
    rsp_pix_next    = rsp_pix;
    mem_we          = 1'b0;
    mem_wa          = clr_addr;
    mem_wd          = 8'd0;
    mem_re          = 1'b0;
    mem_ra          = req.column;

    unique case (depth_mode)
      DEPTH_4: mem_ra = {1'b0, req.column[ADDR_W-1:1]};
      DEPTH_1: mem_ra = {3'd0, req.column[ADDR_W-1:3]};
      default: mem_ra = req.column;
    endcase

    unique case (seq)
      SQ_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == addr_t'(STORE_DEPTH - 1)) begin
          seq_next = SQ_IDLE;
        end
      end
      SQ_IDLE: begin
        if (take) begin
          unique case (req.func)
            FUNC_READ: begin
              mem_re   = 1'b1;
              seq_next = SQ_READ;
            end
            FUNC_END: begin
              rsp_valid_next  = 1'b1;
              rsp_status_next = (phase == PH_PREFIX0) ? ST_END_CLEAN : ST_TRUNCATED;
              rsp_len_next    = '0;
              rsp_pix_next    = '0;
              phase_next      = PH_PREFIX0;
              run_left_next   = '0;
              row_count_next  = '0;
            end
            FUNC_PUSH: begin
              unique case (phase)
                PH_PREFIX0: phase_next = PH_PREFIX1;
                PH_PREFIX1: phase_next = PH_CONTROL;
                PH_CONTROL: begin
                  if (run_in == '0) begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = ST_ROW_DONE;
                    rsp_len_next    = row_count;
                    rsp_pix_next    = '0;
                    phase_next      = PH_PREFIX0;
                    row_count_next  = '0;
                    run_left_next   = '0;
                  end else begin
                    run_left_next = run_in;
                    phase_next    = req.data_byte[7] ? PH_FILL : PH_LITERAL;
                  end
                end
                PH_FILL: begin
                  // Lay the run down over the following cycles
                  if (row_count < {3'd0, limit}) begin
                    seq_next       = SQ_FILL;
                    fill_pos_next  = row_count[WIDTH_W-1:0];
                    fill_left_next = run_left;
                    fill_byte_next = req.data_byte;
                  end
                  row_count_next = count_run;
                  run_left_next  = '0;
                  phase_next     = PH_CONTROL;
                end
                PH_LITERAL: begin
                  if (row_count < {3'd0, limit}) begin
                    mem_we = 1'b1;
                    mem_wa = row_count[ADDR_W-1:0];
                    mem_wd = req.data_byte;
                  end
                  row_count_next = count_one;
                  run_left_next  = run_left - run_t'(1);
                  if (run_left == run_t'(1)) begin
                    phase_next = PH_CONTROL;
                  end
                end
                default: begin
                  phase_next     = PH_PREFIX0;
                  run_left_next  = '0;
                  row_count_next = '0;
                end
              endcase
            end
            default: ;
          endcase
        end
      end
      SQ_FILL: begin
        mem_we         = 1'b1;
        mem_wa         = fill_pos[ADDR_W-1:0];
        mem_wd         = fill_byte;
        fill_pos_next  = fill_pos + width_t'(1);
        fill_left_next = fill_left - run_t'(1);
        // Stop at the end of the run or at the row's byte length
        if (fill_left == run_t'(1) || (fill_pos + width_t'(1)) >= limit) begin
          seq_next = SQ_IDLE;
        end
      end
      SQ_READ: begin
        rsp_valid_next  = 1'b1;
        rsp_status_next = ST_PIXEL;
        rsp_len_next    = '0;
        rsp_pix_next    = pix_sel;
        seq_next        = SQ_IDLE;
      end
      default: seq_next = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd <= store[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq         <= SQ_CLEAR;
      phase       <= PH_PREFIX0;
      run_left    <= '0;
      row_count   <= '0;
      image_width <= width_t'(1);
      depth_mode  <= DEPTH_8;
      clr_addr    <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      seq       <= seq_next;
      phase     <= phase_next;
      run_left  <= run_left_next;
      row_count <= row_count_next;
      rsp_valid <= rsp_valid_next;
      if (seq == SQ_CLEAR) begin
        clr_addr <= clr_addr + addr_t'(1);
      end
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_IMAGE_WIDTH: image_width <= cfg.data;
          REG_DEPTH_MODE:  depth_mode  <= cfg.data[1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fill_pos   <= fill_pos_next;
    fill_left  <= fill_left_next;
    fill_byte  <= fill_byte_next;
    rsp_status <= rsp_status_next;
    rsp_len    <= rsp_len_next;
    rsp_pix    <= rsp_pix_next;
    if (take) begin
      rd_sel <= req.column[2:0];
    end
  end

endmodule

`default_nettype wire
